>>> hdl/sid_pkg.sv
// Shared types and constants for the signed 16-bit to decimal text converter.
package sid_pkg;

    localparam int VALUE_W    = 16;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 5;
    localparam int MAX_CHARS  = 6;
    localparam int PROD_W     = 32;
    localparam int RECIP_SHIFT = 19;

    localparam logic [VALUE_W-1:0] RECIP_TEN  = 16'hCCCD;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
    localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

    typedef struct packed {
        logic                                neg;
        logic [VALUE_W-1:0]                  quot;
        logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;
    } t_conv;

endpackage

>>> hdl/sid_front.sv
// Input stage: sign capture and magnitude of the incoming value.
module sid_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [sid_pkg::VALUE_W-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sid_pkg::t_conv                o_data
);
    import sid_pkg::*;

    logic  r_valid;
    t_conv r_data;
    t_conv n_data;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        n_data.neg    = i_value[VALUE_W-1];
        n_data.quot   = i_value[VALUE_W-1] ? (~i_value + 16'd1) : i_value;
        n_data.digits = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/sid_div_stage.sv
// One pipeline stage: divide the running quotient by ten and keep one digit.
module sid_div_stage #(
    parameter int DIGIT_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sid_pkg::t_conv i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output sid_pkg::t_conv o_data
);
    import sid_pkg::*;

    logic               r_valid;
    t_conv              r_data;
    t_conv              n_data;
    logic [PROD_W-1:0]  v_prod;
    logic [VALUE_W-1:0] v_quot;
    logic [VALUE_W-1:0] v_times_ten;
    logic [VALUE_W-1:0] v_rem;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        v_prod      = i_data.quot * RECIP_TEN;
        v_quot      = {3'b000, v_prod[PROD_W-1:RECIP_SHIFT]};
        v_times_ten = {v_quot[VALUE_W-4:0], 3'b000} + {v_quot[VALUE_W-2:0], 1'b0};
        v_rem       = i_data.quot - v_times_ten;
        n_data                    = i_data;
        n_data.quot               = v_quot;
        n_data.digits[DIGIT_IDX]  = v_rem[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/sid_serializer.sv
// Character builder and output register: one output item per character of each accepted value.
module sid_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  sid_pkg::t_conv              i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sid_pkg::CHAR_W-1:0]  o_char_code,
    output logic                        o_last_char
);
    import sid_pkg::*;

    logic                           r_busy;
    logic [2:0]                     r_pos;
    logic [2:0]                     r_cnt;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] r_chars;
    logic                           r_out_valid;
    logic [CHAR_W-1:0]              r_out_char;
    logic                           r_out_last;

    logic [MAX_CHARS-1:0][CHAR_W-1:0] n_chars;
    logic [2:0]                     n_cnt;
    logic [2:0]                     v_nd;
    logic [2:0]                     v_j;
    logic [2:0]                     v_k;
    logic                           out_free;
    logic                           emit;
    logic                           emit_last;
    logic                           take;

    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = r_busy && out_free;
    assign emit_last = emit && (r_pos == (r_cnt - 3'd1));
    assign o_stall   = r_busy && !emit_last;
    assign take      = i_valid && !o_stall;

    always_comb begin
        v_nd = 3'd1;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (i_data.digits[k] != '0) begin
                v_nd = 3'(k + 1);
            end
        end
        n_cnt = v_nd + {2'b00, i_data.neg};
        for (int p = 0; p < MAX_CHARS; p++) begin
            v_j = 3'(p) - {2'b00, i_data.neg};
            v_k = v_nd - 3'd1 - v_j;
            if (i_data.neg && (p == 0)) begin
                n_chars[p] = CHAR_MINUS;
            end else if (v_k < 3'(NUM_DIGITS)) begin
                n_chars[p] = CHAR_ZERO + {2'b00, i_data.digits[v_k]};
            end else begin
                n_chars[p] = CHAR_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
                r_cnt  <= n_cnt;
            end else if (emit_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_pos <= r_pos + 3'd1;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_chars <= n_chars;
        end
        if (emit) begin
            r_out_char <= r_chars[r_pos];
            r_out_last <= (r_pos == (r_cnt - 3'd1));
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last_char = r_out_last;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < r_cnt))
        else $error("character position beyond count");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_cnt != 3'd0) && (r_cnt <= 3'(MAX_CHARS))))
        else $error("character count out of range");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_char == CHAR_MINUS) ||
                         ((r_out_char >= CHAR_ZERO) && (r_out_char <= CHAR_ZERO + 6'd9))))
        else $error("illegal character code");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_char == CHAR_MINUS)) |-> !r_out_last)
        else $error("minus sign flagged as last character");

endmodule

>>> hdl/signed_int16_to_decimal_ascii_core.sv
// Top level of the signed 16-bit to decimal ASCII converter.
// Each accepted item is a signed 16-bit value; its decimal text leaves as one item per
// character, most significant first, with '-' ahead of negative values, no leading zeros,
// and o_last_char set on the final character (-32768 prints in full). A value passes a
// magnitude stage and five divide-by-ten stages (one reciprocal multiply each), each registered,
// before the character builder, which registers its characters and then the output register. The
// single output port moves one character per cycle while i_stall is low, and a value's text takes
// one to six characters; back to back values stream without gaps.
module signed_int16_to_decimal_ascii_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sid_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sid_pkg::CHAR_W-1:0]         o_char_code,
    output logic                               o_last_char
);
    import sid_pkg::*;

    logic  [NUM_DIGITS:0] stg_valid;
    logic  [NUM_DIGITS:0] stg_stall;
    t_conv                stg_data [NUM_DIGITS+1];

    sid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_valid (stg_valid[0]),
        .i_stall (stg_stall[0]),
        .o_data  (stg_data[0])
    );

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_div
        sid_div_stage #(
            .DIGIT_IDX (g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_stall (stg_stall[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_stall (stg_stall[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    sid_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid[NUM_DIGITS]),
        .o_stall     (stg_stall[NUM_DIGITS]),
        .i_data      (stg_data[NUM_DIGITS]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule
